FILE: rtl/lsm_pkg.sv
package lsm_pkg;

  // Register file layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_LINE = 3'd0,
    CFG_IGNORE_COUNT     = 3'd1,
    CFG_METRIC_MODE      = 3'd2,
    CFG_THRESHOLD        = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_SUM   = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_PEAK  = 2'd2,
    MODE_GRAD  = 2'd3
  } metric_mode_t;

  // Register widths and reset values
  localparam int SPL_W   = 13;
  localparam int IGN_W   = 13;
  localparam int THR_W   = 24;
  localparam logic [SPL_W-1:0] SPL_RESET = 13'd1024;

  // Result widths
  localparam int TOTAL_W = 56;
  localparam int LINES_W = 16;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Count metric is scaled to Q.8
  localparam int COUNT_SHIFT = 8;
  // Gradient metric needs this many used samples
  localparam int MIN_GRAD_SAMPLES = 3;

  // Depth of the queue between front and back end
  localparam int EVQ_DEPTH = 4;

  // Control part of a line/frame event
  typedef struct packed {
    logic         line_done;
    logic         eof;
    metric_mode_t mode;
  } lsm_ev_ctrl_t;

endpackage

FILE: rtl/line_sharpness_metric_accumulator_unit.sv
// Front end takes one sample per cycle while its four-entry event queue has room.
// Back end pops one queued event at a time while idle. A line end runs the divider over
// every accumulator bit for a gradient line of 3+ samples, then adds its metric to the
// frame total; a frame end then emits the total (directly if no line ends on it), once
// any earlier result has been taken.
// Synchronous active-low reset clears the control state, counters and accumulators and loads the register defaults.
module line_sharpness_metric_accumulator_unit #(
  parameter int MAX_LINE_SAMPLES = 4096,
  parameter int SAMPLE_BITS      = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic                                   in_end_of_frame,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [lsm_pkg::TOTAL_W-1:0]     out_total_metric,
  output logic [lsm_pkg::LINES_W-1:0]            out_lines_in_frame,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import lsm_pkg::*;

  localparam int LW    = $clog2(MAX_LINE_SAMPLES + 1);
  localparam int ACC_W = SAMPLE_BITS + LW + 2;
  localparam int CTL_W = $bits(lsm_ev_ctrl_t);
  localparam int EV_W  = CTL_W + LW + ACC_W;

  logic [SPL_W-1:0]        spl_r;
  logic [IGN_W-1:0]        ignore_r;
  metric_mode_t            mode_r;
  logic signed [THR_W-1:0] thresh_r;

  logic                    accept;
  logic                    ev_push;
  lsm_ev_ctrl_t            fe_ctrl;
  logic signed [ACC_W-1:0] fe_acc;
  logic [LW-1:0]           fe_used;
  logic [EV_W-1:0]         evq_wdata;
  logic [EV_W-1:0]         evq_rdata;
  logic                    evq_full;
  logic                    evq_empty;
  logic                    evq_pop;
  lsm_ev_ctrl_t            be_ctrl;
  logic signed [ACC_W-1:0] be_acc;
  logic [LW-1:0]           be_used;

  assign cfg_ready = 1'b1;
  assign full      = evq_full;
  assign accept    = push && !evq_full;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spl_r    <= SPL_RESET;
      ignore_r <= '0;
      mode_r   <= MODE_SUM;
      thresh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLES_PER_LINE: spl_r    <= cfg_data[SPL_W-1:0];
        CFG_IGNORE_COUNT:     ignore_r <= cfg_data[IGN_W-1:0];
        CFG_METRIC_MODE:      mode_r   <= metric_mode_t'(cfg_data[1:0]);
        CFG_THRESHOLD:        thresh_r <= $signed(cfg_data[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  lsm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LW          (LW),
    .ACC_W       (ACC_W),
    .MAX_LINE    (MAX_LINE_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_spl    (spl_r),
    .cfg_ignore (ignore_r),
    .cfg_mode   (mode_r),
    .cfg_thresh (thresh_r),
    .accept     (accept),
    .sample     (in_sample),
    .eof        (in_end_of_frame),
    .ev_push    (ev_push),
    .ev_ctrl    (fe_ctrl),
    .ev_acc     (fe_acc),
    .ev_used    (fe_used)
  );

  // Pack and unpack queue entries
  assign evq_wdata = {fe_ctrl, fe_used, fe_acc};
  assign be_ctrl   = lsm_ev_ctrl_t'(evq_rdata[EV_W-1 -: CTL_W]);
  assign be_used   = evq_rdata[ACC_W +: LW];
  assign be_acc    = $signed(evq_rdata[ACC_W-1:0]);

  lsm_fifo #(
    .WIDTH (EV_W),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_push),
    .wr_data (evq_wdata),
    .full    (evq_full),
    .rd_en   (evq_pop),
    .rd_data (evq_rdata),
    .empty   (evq_empty)
  );

  lsm_back #(
    .LW    (LW),
    .ACC_W (ACC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evq_empty (evq_empty),
    .evq_pop   (evq_pop),
    .ev_ctrl   (be_ctrl),
    .ev_acc    (be_acc),
    .ev_used   (be_used),
    .out_pop   (pop),
    .out_empty (empty),
    .out_total (out_total_metric),
    .out_lines (out_lines_in_frame)
  );

endmodule

FILE: rtl/lsm_fifo.sv
module lsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lsm_front.sv
module lsm_front #(
  parameter int SAMPLE_BITS = 24,
  parameter int LW          = 13,
  parameter int ACC_W       = 39,
  parameter int MAX_LINE    = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lsm_pkg::SPL_W-1:0]     cfg_spl,
  input  logic [lsm_pkg::IGN_W-1:0]     cfg_ignore,
  input  lsm_pkg::metric_mode_t         cfg_mode,
  input  logic signed [lsm_pkg::THR_W-1:0] cfg_thresh,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          eof,
  output logic                          ev_push,
  output lsm_pkg::lsm_ev_ctrl_t         ev_ctrl,
  output logic signed [ACC_W-1:0]       ev_acc,
  output logic [LW-1:0]                 ev_used
);
  import lsm_pkg::*;

  localparam int CMP_W = (LW > SPL_W) ? LW : SPL_W;
  localparam int TW    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_LINE);

  logic [LW-1:0]                 pos_r, pos_nxt;
  logic [LW-1:0]                 used_r, used_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] prev0_r, prev0_nxt;
  logic signed [SAMPLE_BITS-1:0] prev1_r, prev1_nxt;

  logic [CMP_W-1:0]              len;
  logic                          active;
  logic                          use_smp;
  logic                          above;
  logic signed [ACC_W-1:0]       s_ext;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          adiff;
  logic signed [ACC_W-1:0]       acc_step;
  logic [LW-1:0]                 pos_inc;
  logic [LW-1:0]                 used_inc;
  logic                          line_end;

  // Classify the sample against the line geometry
  always_comb begin
    len      = (CMP_W'(cfg_spl) > MAX_LEN) ? MAX_LEN : CMP_W'(cfg_spl);
    active   = (len != '0);
    use_smp  = (CMP_W'(pos_r) >= CMP_W'(cfg_ignore));
    pos_inc  = pos_r + 1'b1;
    line_end = active && (CMP_W'(pos_inc) >= len);
    used_inc = use_smp ? used_r + 1'b1 : used_r;
  end

  // Update the line accumulator for the current mode
  always_comb begin
    above = (TW'(sample) > TW'(cfg_thresh));
    s_ext = ACC_W'(sample);
    diff  = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(prev1_r);
    adiff = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
    unique case (cfg_mode)
      MODE_SUM:   acc_step = above ? acc_r + s_ext : acc_r;
      MODE_COUNT: acc_step = above ? acc_r + ACC_W'(1) : acc_r;
      MODE_PEAK:  acc_step = (s_ext > acc_r) ? s_ext : acc_r;
      MODE_GRAD:  acc_step = (used_r >= LW'(2)) ?
                             acc_r + $signed(ACC_W'(adiff)) : acc_r;
      default:    acc_step = acc_r;
    endcase
  end

  // Emit an event on line end or frame end
  assign ev_push             = accept && (line_end || eof);
  assign ev_ctrl.line_done   = line_end;
  assign ev_ctrl.eof         = eof;
  assign ev_ctrl.mode        = cfg_mode;
  assign ev_acc              = use_smp ? acc_step : acc_r;
  assign ev_used             = used_inc;

  // Next line state: drop on event, else advance the position, and the rest on a used sample
  always_comb begin
    pos_nxt   = pos_r;
    used_nxt  = used_r;
    acc_nxt   = acc_r;
    prev0_nxt = prev0_r;
    prev1_nxt = prev1_r;
    if (accept) begin
      if (line_end || eof) begin
        pos_nxt   = '0;
        used_nxt  = '0;
        acc_nxt   = '0;
        prev0_nxt = '0;
        prev1_nxt = '0;
      end else if (active) begin
        pos_nxt = pos_inc;
        if (use_smp) begin
          acc_nxt   = acc_step;
          used_nxt  = used_inc;
          prev1_nxt = prev0_r;
          prev0_nxt = sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      used_r  <= '0;
      acc_r   <= '0;
      prev0_r <= '0;
      prev1_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      used_r  <= used_nxt;
      acc_r   <= acc_nxt;
      prev0_r <= prev0_nxt;
      prev1_r <= prev1_nxt;
    end
  end

endmodule

FILE: rtl/lsm_back.sv
module lsm_back #(
  parameter int LW    = 13,
  parameter int ACC_W = 39
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 evq_empty,
  output logic                                 evq_pop,
  input  lsm_pkg::lsm_ev_ctrl_t                ev_ctrl,
  input  logic signed [ACC_W-1:0]              ev_acc,
  input  logic [LW-1:0]                        ev_used,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [lsm_pkg::TOTAL_W-1:0]   out_total,
  output logic [lsm_pkg::LINES_W-1:0]          out_lines
);
  import lsm_pkg::*;

  localparam int MET_W = ACC_W + COUNT_SHIFT;
  localparam int SUM_W = ((MET_W > TOTAL_W) ? MET_W : TOTAL_W) + 1;
  localparam int DVD_W = ACC_W;
  localparam int DVS_W = LW + 1;
  localparam int REM_W = LW + 2;
  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_EMIT
  } state_t;

  state_t                    state_r;
  logic                      eof_r;
  logic signed [MET_W-1:0]   metric_r;
  logic [DVD_W-1:0]          dvd_r;
  logic [DVS_W-1:0]          dvs_r;
  logic [REM_W-1:0]          rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      neg_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic [LINES_W-1:0]        lines_r;
  logic                      out_valid_r;
  logic signed [TOTAL_W-1:0] out_total_r;
  logic [LINES_W-1:0]        out_lines_r;

  logic [LW-1:0]             inner;
  logic                      grad_ok;
  logic signed [ACC_W:0]     num;
  logic [ACC_W:0]            num_mag;
  logic [REM_W-1:0]          rem_sh;
  logic                      rem_ge;
  logic [DVD_W-1:0]          quo;
  logic signed [SUM_W-1:0]   sum;
  logic signed [TOTAL_W-1:0] sum_sat;
  logic                      out_free;
  logic                      emit_go;

  assign evq_pop   = (state_r == S_IDLE) && !evq_empty;
  assign out_empty = !out_valid_r;
  assign out_total = out_total_r;
  assign out_lines = out_lines_r;
  assign out_free  = !out_valid_r || out_pop;
  assign emit_go   = (state_r == S_EMIT) && out_free;

  // Divider step and saturating add
  always_comb begin
    inner   = ev_used - LW'(2);
    grad_ok = (ev_used >= LW'(MIN_GRAD_SAMPLES));
    // Rounding numerator; divide its magnitude and restore the sign after
    num     = (ACC_W+1)'(ev_acc) + $signed((ACC_W+1)'(inner));
    num_mag = num[ACC_W] ? $unsigned(-num) : $unsigned(num);
    rem_sh  = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
    rem_ge  = (rem_sh >= REM_W'(dvs_r));
    quo     = {dvd_r[DVD_W-2:0], rem_ge};
    sum     = SUM_W'(total_r) + SUM_W'(metric_r);
    if (sum > SUM_W'(TOTAL_MAX)) begin
      sum_sat = TOTAL_MAX;
    end else if (sum < SUM_W'(TOTAL_MIN)) begin
      sum_sat = TOTAL_MIN;
    end else begin
      sum_sat = sum[TOTAL_W-1:0];
    end
  end

  // Sequence each event: metric and accumulate on a line end, emit on a frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eof_r       <= 1'b0;
      total_r     <= '0;
      lines_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // Hold the result until it is taken or replaced
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!evq_empty) begin
            eof_r <= ev_ctrl.eof;
            if (!ev_ctrl.line_done) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_ADD;
              unique case (ev_ctrl.mode)
                MODE_SUM, MODE_PEAK: metric_r <= MET_W'(ev_acc);
                MODE_COUNT: metric_r <= {ev_acc, {COUNT_SHIFT{1'b0}}};
                MODE_GRAD: begin
                  metric_r <= '0;
                  if (grad_ok) begin
                    dvd_r   <= num_mag[DVD_W-1:0];
                    neg_r   <= num[ACC_W];
                    dvs_r   <= {inner, 1'b0};
                    rem_r   <= '0;
                    cnt_r   <= CNT_W'(DVD_W);
                    state_r <= S_DIV;
                  end
                end
                default: metric_r <= '0;
              endcase
            end
          end
        end
        S_DIV: begin
          // One quotient bit per cycle, restoring
          rem_r <= rem_ge ? rem_sh - REM_W'(dvs_r) : rem_sh;
          dvd_r <= quo;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            metric_r <= neg_r ? -$signed(MET_W'(quo)) : $signed(MET_W'(quo));
            state_r  <= S_ADD;
          end
        end
        S_ADD: begin
          total_r <= sum_sat;
          if (lines_r != '1) begin
            lines_r <= lines_r + 1'b1;
          end
          state_r <= eof_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_total_r <= total_r;
            out_lines_r <= lines_r;
            total_r     <= '0;
            lines_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lsm_checker.sv
module lsm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [lsm_pkg::TOTAL_W-1:0]  out_total_metric,
  input logic [lsm_pkg::LINES_W-1:0]         out_lines_in_frame
);

  // A waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_total_metric)
                          && $stable(out_lines_in_frame)))
    else $error("result changed while waiting");

  // A frame without complete lines has a zero total
  a_zero_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_lines_in_frame == '0)) |-> (out_total_metric == '0))
    else $error("nonzero total with no complete lines");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

  // Reset leaves the input side open
  a_reset_open: assert property (@(posedge clk)
    !rst_n |=> !full)
    else $error("input full after reset");

endmodule

bind line_sharpness_metric_accumulator_unit lsm_checker u_lsm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_total_metric   (out_total_metric),
  .out_lines_in_frame (out_lines_in_frame)
);

FILE: tb/tb_line_sharpness_metric_accumulator_unit.sv
module tb_line_sharpness_metric_accumulator_unit;
  import lsm_pkg::*;

  localparam int     LINE_CAP       = 4096;
  localparam int     SAMPLE_W       = 24;
  localparam int     LINES_SAT      = 65535;
  localparam int     FIELD13_MAX    = (1 << SPL_W) - 1;
  localparam int     SETTLE_CYCLES  = 400;
  localparam int     RX_HOLD_CYCLES = 600;
  localparam int     TARGET_ITEMS   = 1300;
  localparam longint CYCLE_LIMIT    = 3000000;
  localparam longint SAMPLE_MAX     = 64'sd8388607;
  localparam longint SAMPLE_MIN     = -64'sd8388608;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [LINES_W-1:0] lines;
  } frame_result_t;

  // Mirror of the line/frame accumulation, one frame result per end-of-frame sample
  class frame_metric_scoreboard;
    logic [SPL_W-1:0] line_len_reg;
    logic [IGN_W-1:0] skip_reg;
    metric_mode_t     mode_reg;
    longint           thr;
    int unsigned      pos;
    int unsigned      used;
    longint           line_acc;
    longint           recent [2];
    longint           frame_total;
    int unsigned      line_count;
    frame_result_t    expected_q [$];
    int               errors;

    function new();
      line_len_reg = SPL_RESET;
      skip_reg     = '0;
      mode_reg     = MODE_SUM;
      thr          = 0;
      errors       = 0;
      clear_frame();
    endfunction

    function void clear_line();
      pos       = 0;
      used      = 0;
      line_acc  = 0;
      recent[0] = 0;
      recent[1] = 0;
    endfunction

    function void clear_frame();
      clear_line();
      frame_total = 0;
      line_count  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLES_PER_LINE: line_len_reg = data[SPL_W-1:0];
        CFG_IGNORE_COUNT:     skip_reg = data[IGN_W-1:0];
        CFG_METRIC_MODE:      mode_reg = metric_mode_t'(data[1:0]);
        CFG_THRESHOLD:        thr = longint'($signed(data[THR_W-1:0]));
        default: ;
      endcase
    endfunction

    // Metric of a finished line under the mode in force at its end
    function longint line_metric();
      longint c;
      longint m;
      case (mode_reg)
        MODE_COUNT: m = line_acc * 256;
        MODE_GRAD: begin
          if (used < MIN_GRAD_SAMPLES) m = 0;
          else begin
            c = longint'(used) - 2;
            m = (line_acc + c) / (2 * c);
          end
        end
        default: m = line_acc;
      endcase
      return m;
    endfunction

    function void absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic eof);
      int unsigned   len;
      longint        x;
      longint        d;
      longint        t;
      frame_result_t r;
      x   = longint'(s);
      len = (line_len_reg > LINE_CAP) ? LINE_CAP : line_len_reg;
      if (len > 0) begin
        // Accumulate only past the skipped head of the line
        if (pos >= skip_reg) begin
          case (mode_reg)
            MODE_SUM:   if (x > thr) line_acc += x;
            MODE_COUNT: if (x > thr) line_acc += 1;
            MODE_PEAK:  if (x > line_acc) line_acc = x;
            default: begin
              if (used >= 2) begin
                d = x - recent[1];
                line_acc += (d < 0) ? -d : d;
              end
            end
          endcase
          recent[1] = recent[0];
          recent[0] = x;
          used++;
        end
        pos++;
        // Close the line: fold its metric into the saturating frame total
        if (pos >= len) begin
          t = frame_total + line_metric();
          if (t > longint'(TOTAL_MAX)) t = longint'(TOTAL_MAX);
          if (t < longint'(TOTAL_MIN)) t = longint'(TOTAL_MIN);
          frame_total = t;
          if (line_count < LINES_SAT) line_count++;
          clear_line();
        end
      end
      if (eof) begin
        r.total = frame_total[TOTAL_W-1:0];
        r.lines = line_count[LINES_W-1:0];
        expected_q.push_back(r);
        clear_frame();
      end
    endfunction

    task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_frame_result(input logic [TOTAL_W-1:0] total, input logic [LINES_W-1:0] lines);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no frame pending: total %0d lines %0d",
                                  $signed(total), lines));
      end else begin
        want = expected_q.pop_front();
        if (total !== want.total)
          report_mismatch($sformatf("total_metric got %0d want %0d",
                                    $signed(total), $signed(want.total)));
        if (lines !== want.lines)
          report_mismatch($sformatf("lines_in_frame got %0d want %0d", lines, want.lines));
      end
    endtask
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              push;
  logic                              full;
  logic signed [SAMPLE_W-1:0]        in_sample;
  logic                              in_end_of_frame;
  logic                              empty;
  logic                              pop;
  logic signed [TOTAL_W-1:0]         out_total_metric;
  logic [LINES_W-1:0]                out_lines_in_frame;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index;
  logic [CFG_DATA_W-1:0]             cfg_data;

  frame_metric_scoreboard sb;
  int unsigned            items_sent;
  bit                     rx_hold_req;
  bit                     tx_steady;
  bit                     rx_steady;

  line_sharpness_metric_accumulator_unit #(
    .MAX_LINE_SAMPLES(LINE_CAP),
    .SAMPLE_BITS     (SAMPLE_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_sample         (in_sample),
    .in_end_of_frame   (in_end_of_frame),
    .empty             (empty),
    .pop               (pop),
    .out_total_metric  (out_total_metric),
    .out_lines_in_frame(out_lines_in_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Generate the clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none in a steady stretch
  function automatic int unsigned idle_len(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Pick a Q15.8 value: extremes, near a center, small, or anywhere in range
  function automatic logic signed [SAMPLE_W-1:0] pick_value(input longint center);
    longint v;
    case ($urandom_range(0, 9))
      0:       v = SAMPLE_MAX;
      1:       v = SAMPLE_MIN;
      2, 3, 4: v = center + longint'($urandom_range(0, 1024)) - 512;
      5:       v = longint'($urandom_range(0, 4096)) - 2048;
      default: v = longint'($urandom_range(0, 16777215)) + SAMPLE_MIN;
    endcase
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eof);
    int unsigned gap;
    gap = idle_len(tx_steady);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push            <= 1'b1;
    in_sample       <= s;
    in_end_of_frame <= eof;
    do @(posedge clk); while (full);
  endtask

  task automatic send_frame(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_sample(pick_value(sb.thr), i == n - 1);
    items_sent += n;
  endtask

  // Drop push, wait for every pending frame result, then let the back end drain
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load all registers with junk in the unused upper data bits
  task automatic reconfigure(input int unsigned spl, input int unsigned ign,
                             input metric_mode_t mode, input longint thr);
    logic [CFG_DATA_W-1:0] d;
    logic [CFG_IDX_W-1:0]  spare;
    wait_idle();
    d = CFG_DATA_W'($urandom);
    d[SPL_W-1:0] = spl[SPL_W-1:0];
    cfg_write(CFG_SAMPLES_PER_LINE, d);
    d = CFG_DATA_W'($urandom);
    d[IGN_W-1:0] = ign[IGN_W-1:0];
    cfg_write(CFG_IGNORE_COUNT, d);
    d = CFG_DATA_W'($urandom);
    d[1:0] = mode;
    cfg_write(CFG_METRIC_MODE, d);
    cfg_write(CFG_THRESHOLD, thr[CFG_DATA_W-1:0]);
    // Hit an index past the register file; it must change nothing
    if ($urandom_range(0, 3) == 0) begin
      spare = CFG_IDX_W'($urandom_range(int'(CFG_THRESHOLD) + 1, (1 << CFG_IDX_W) - 1));
      d = CFG_DATA_W'($urandom);
      cfg_write(spare, d);
    end
  endtask

  // Observe transfers on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_frame_result(out_total_metric, out_lines_in_frame);
      if (push && !full) sb.absorb_sample(in_sample, in_end_of_frame);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Drive pop with random gaps and, on request, one long hold-off
  initial begin
    int unsigned gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      gap = idle_len(rx_steady);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  // Abort a hung run
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned  pick;
    int unsigned  spl;
    int unsigned  eff;
    int unsigned  ign;
    int unsigned  n;
    metric_mode_t mode;
    longint       thr;

    rst_n           = 1'b0;
    push            = 1'b0;
    in_sample       = '0;
    in_end_of_frame = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    items_sent      = 0;
    sb              = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: a short frame is only a partial line
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b1);

    // Sum above zero on 3-sample lines, trailing partial line dropped
    reconfigure(3, 0, MODE_SUM, 0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sd256, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd7, 1'b1);

    // Count against the lowest threshold
    reconfigure(3, 0, MODE_COUNT, SAMPLE_MIN);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sd0, 1'b1);

    // Peak of negative samples floors at zero; the line ends on the end-of-frame sample
    reconfigure(3, 1, MODE_PEAK, SAMPLE_MAX);
    send_sample(-24'sd5, 1'b0);
    send_sample(-24'sd7, 1'b0);
    send_sample(-24'sd3, 1'b1);

    // Gradient over full-swing samples
    reconfigure(5, 0, MODE_GRAD, 0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sd100, 1'b1);

    // Zero line length ignores samples
    reconfigure(0, 0, MODE_SUM, 0);
    send_sample(24'sd1000, 1'b1);

    // Skip count past the line end: line counts, metric zero
    reconfigure(2, FIELD13_MAX, MODE_SUM, SAMPLE_MIN);
    send_sample(24'sd100, 1'b0);
    send_sample(24'sd200, 1'b1);

    // Switch mode halfway through a line
    reconfigure(4, 0, MODE_SUM, 0);
    send_sample(24'sd1000, 1'b0);
    send_sample(24'sd2000, 1'b0);
    wait_idle();
    cfg_write(CFG_METRIC_MODE, {{(CFG_DATA_W-2){1'b0}}, MODE_PEAK});
    send_sample(24'sd500, 1'b0);
    send_sample(24'sd300, 1'b1);

    // Hold off the receiver while one- and two-sample frames pile up
    reconfigure(1, 0, MODE_COUNT, 0);
    tx_steady   = 1'b1;
    rx_hold_req = 1'b1;
    repeat (40) send_frame($urandom_range(1, 2));
    wait_idle();

    // Random phases: mostly whole lines, some partial tails
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 13)      spl = $urandom_range(1, 12);
      else if (pick < 15) spl = 0;
      else if (pick < 18) spl = $urandom_range(13, 64);
      else                spl = $urandom_range(65, FIELD13_MAX);
      eff = (spl > LINE_CAP) ? LINE_CAP : spl;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ign = 0;
        4, 5, 6, 7: ign = $urandom_range(0, eff + 1);
        8:          ign = $urandom_range(0, FIELD13_MAX);
        default:    ign = FIELD13_MAX;
      endcase
      mode = metric_mode_t'($urandom_range(0, 3));
      thr  = ($urandom_range(0, 3) == 0) ? 0 : pick_value(0);
      reconfigure(spl, ign, mode, thr);
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(3, 8)) begin
        if (items_sent >= TARGET_ITEMS) break;
        if (eff == 0 || eff > 64) n = $urandom_range(1, 12);
        else begin
          n = eff * $urandom_range(0, 4);
          if (eff > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, eff - 1);
          if (n == 0) n = 1;
        end
        send_frame(n);
      end
    end

    // Oversized line length: a short frame stays a partial line
    reconfigure(FIELD13_MAX, 4000, MODE_GRAD, 0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_frame(40);

    wait_idle();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: line_sharpness_metric_accumulator_unit.f
rtl/lsm_pkg.sv
rtl/lsm_fifo.sv
rtl/lsm_front.sv
rtl/lsm_back.sv
rtl/line_sharpness_metric_accumulator_unit.sv
rtl/lsm_checker.sv
tb/tb_line_sharpness_metric_accumulator_unit.sv
